// ===== rtl/mdnp_pkg.sv =====
// shared types, constants and helper functions for the mouse nibble port
// no dependencies; used by the interfaces, controller, datapath and top level
package mdnp_pkg;

   // field widths
   localparam int unsigned TIMEOUT_W         = 10;
   localparam int unsigned TIME_BITS_DEFAULT = 10;
   localparam int unsigned ACC_W             = 8;
   localparam int unsigned DIV_W             = 4;

   // reset and range constants
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd300;
   localparam logic [DIV_W-1:0]     DIV_LOW       = 4'd2;
   localparam logic [DIV_W-1:0]     DIV_HIGH      = 4'd8;
   localparam logic [DIV_W-1:0]     DIV_STEP      = 4'd2;
   localparam logic signed [ACC_W:0] ACC_MIN      = -9'sd128;
   localparam logic signed [ACC_W:0] ACC_MAX      = 9'sd127;
   // reciprocal of three over 2^9, exact for values below 256
   localparam logic [7:0]           RECIP_3       = 8'd171;

   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,
      CMD_STROBE = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PHASE_X_HI = 2'd0,
      PHASE_X_LO = 2'd1,
      PHASE_Y_HI = 2'd2,
      PHASE_Y_LO = 2'd3
   } phase_type;

   typedef struct packed {
      cmd_type           command;
      logic [2:0]        buttons;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
      logic              edge_rising;
   } req_item_type;

   typedef struct packed {
      logic [3:0] data_lines;
      logic       left_pulled_low;
      logic       right_pulled_low;
      logic [1:0] nibble_phase;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic step_div;
      logic step_quot;
      logic step_apply;
      logic load_out;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_is_report;
      logic out_busy;
   } dp_status_type;

   // magnitude divided by 2, 4, 6 or 8, truncated
   function automatic logic [6:0] div_mag(input logic [7:0] mag, input logic [DIV_W-1:0] dv);
      logic [15:0] prod;
      logic [6:0]  q;
      prod = 16'(mag[7:1]) * 16'(RECIP_3);
      unique case (dv)
         4'd4:    q = 7'(mag >> 2);
         4'd6:    q = 7'(prod >> 9);
         4'd8:    q = 7'(mag >> 3);
         default: q = 7'(mag >> 1);
      endcase
      return q;
   endfunction

   // nibble of the latched pair for a phase
   function automatic logic [3:0] nibble_for(input logic [1:0] ph,
                                             input logic [7:0] xb,
                                             input logic [7:0] yb);
      logic [3:0] n;
      unique case (phase_type'(ph))
         PHASE_X_HI: n = xb[7:4];
         PHASE_X_LO: n = xb[3:0];
         PHASE_Y_HI: n = yb[7:4];
         PHASE_Y_LO: n = yb[3:0];
         default:    n = yb[3:0];
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/mdnp_if.sv =====
// valid/ready channel interfaces for requests, responses and the csr write
// depends on mdnp_pkg
interface mdnp_req_if import mdnp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        command;
   logic [2:0]        buttons;
   logic signed [7:0] delta_x;
   logic signed [7:0] delta_y;
   logic              edge_rising;

   modport source (output valid, command, buttons, delta_x, delta_y, edge_rising,
                   input ready);
   modport sink   (input valid, command, buttons, delta_x, delta_y, edge_rising,
                   output ready);
endinterface

interface mdnp_rsp_if import mdnp_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [3:0] data_lines;
   logic       left_pulled_low;
   logic       right_pulled_low;
   logic [1:0] nibble_phase;

   modport source (output valid, data_lines, left_pulled_low, right_pulled_low,
                   nibble_phase, input ready);
   modport sink   (input valid, data_lines, left_pulled_low, right_pulled_low,
                   nibble_phase, output ready);
endinterface

interface mdnp_csr_if import mdnp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TIMEOUT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/mdnp_ctrl.sv =====
// sequencing state machine: accepts one request, steps the datapath, emits a response
// depends on mdnp_pkg
module mdnp_ctrl import mdnp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_QUOT,
      ST_APPLY,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.req_is_report ? ST_DIV : ST_APPLY;
            end
         end
         ST_DIV:   state_in = ST_QUOT;
         ST_QUOT:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath commands decoded from state
   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.step_div   = (state_ff == ST_DIV);
      cmd.step_quot  = (state_ff == ST_QUOT);
      cmd.step_apply = (state_ff == ST_APPLY);
      cmd.load_out   = (state_ff == ST_EMIT) && !status.out_busy;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/mdnp_dp.sv =====
// datapath: accumulators, divisor, strobe phase, timeout counter and output register
// depends on mdnp_pkg
module mdnp_dp import mdnp_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  req_item_type         req_item,
   input  logic                 csr_write,
   input  logic [TIMEOUT_W-1:0] csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_item_type         rsp_item
);

   localparam int unsigned CMP_W = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // captured request
   req_item_type req_ff;

   // architectural state
   logic [TIMEOUT_W-1:0]    timeout_ff;
   logic signed [ACC_W-1:0] accum_x_ff, accum_y_ff;
   logic [ACC_W-1:0]        latched_x_ff, latched_y_ff;
   logic [1:0]              phase_ff;
   logic [TIME_BITS-1:0]    since_ff;
   logic                    middle_ff;
   logic [DIV_W-1:0]        divisor_ff;
   logic [3:0]              lines_ff;
   logic [1:0]              drive_ff;

   // signed quotients, already negated for the accumulator
   logic signed [ACC_W-1:0] quot_x_ff, quot_y_ff;

   // output register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   // combinational helpers
   logic [7:0]              mag_x, mag_y;
   logic [6:0]              q_x, q_y;
   logic signed [ACC_W:0]   sum_x, sum_y;
   logic signed [ACC_W-1:0] sat_x, sat_y;
   logic [1:0]              phase_next;
   logic                    timed_out;
   logic [ACC_W-1:0]        lat_x_next, lat_y_next;

   assign status.req_is_report = (req_item.command == CMD_REPORT);
   assign status.out_busy      = rsp_valid_ff & ~rsp_ready;

   // magnitude and quotient of each delta
   always_comb begin
      mag_x = req_ff.delta_x[7] ? 8'(-req_ff.delta_x) : 8'(req_ff.delta_x);
      mag_y = req_ff.delta_y[7] ? 8'(-req_ff.delta_y) : 8'(req_ff.delta_y);
      q_x   = div_mag(mag_x, divisor_ff);
      q_y   = div_mag(mag_y, divisor_ff);
   end

   // accumulate and saturate
   always_comb begin
      sum_x = (ACC_W+1)'(accum_x_ff) + (ACC_W+1)'(quot_x_ff);
      sum_y = (ACC_W+1)'(accum_y_ff) + (ACC_W+1)'(quot_y_ff);
      if (sum_x < ACC_MIN) begin
         sat_x = ACC_W'(ACC_MIN);
      end else if (sum_x > ACC_MAX) begin
         sat_x = ACC_W'(ACC_MAX);
      end else begin
         sat_x = sum_x[ACC_W-1:0];
      end
      if (sum_y < ACC_MIN) begin
         sat_y = ACC_W'(ACC_MIN);
      end else if (sum_y > ACC_MAX) begin
         sat_y = ACC_W'(ACC_MAX);
      end else begin
         sat_y = sum_y[ACC_W-1:0];
      end
   end

   // strobe phase step and latch
   always_comb begin
      timed_out  = CMP_W'(since_ff) > CMP_W'(timeout_ff);
      phase_next = (req_ff.edge_rising && timed_out) ? 2'd0 : phase_ff + 2'd1;
      lat_x_next = (phase_next == 2'd0) ? accum_x_ff : latched_x_ff;
      lat_y_next = (phase_next == 2'd0) ? accum_y_ff : latched_y_ff;
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
   end

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write) begin
         timeout_ff <= csr_data;
      end
   end

   // divisor, middle button and button lines
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= DIV_LOW;
         middle_ff  <= 1'b0;
         drive_ff   <= 2'b00;
      end else if (cmd.step_div) begin
         if (!middle_ff && req_ff.buttons[2]) begin
            divisor_ff <= (divisor_ff >= DIV_HIGH) ? DIV_LOW : divisor_ff + DIV_STEP;
         end
         middle_ff <= req_ff.buttons[2];
         drive_ff  <= req_ff.buttons[1:0];
      end
   end

   // quotient registers
   always_ff @(posedge clock) begin
      if (cmd.step_quot) begin
         quot_x_ff <= req_ff.delta_x[7] ? ACC_W'(q_x) : -ACC_W'(q_x);
         quot_y_ff <= req_ff.delta_y[7] ? ACC_W'(q_y) : -ACC_W'(q_y);
      end
   end

   // command execution
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_x_ff   <= '0;
         accum_y_ff   <= '0;
         latched_x_ff <= '0;
         latched_y_ff <= '0;
         phase_ff     <= 2'd0;
         since_ff     <= TIME_MAX;
         lines_ff     <= 4'hF;
      end else if (cmd.step_apply) begin
         unique case (req_ff.command)
            CMD_REPORT: begin
               accum_x_ff <= sat_x;
               accum_y_ff <= sat_y;
            end
            CMD_STROBE: begin
               phase_ff     <= phase_next;
               since_ff     <= '0;
               latched_x_ff <= lat_x_next;
               latched_y_ff <= lat_y_next;
               lines_ff     <= nibble_for(phase_next, lat_x_next, lat_y_next);
               if (phase_next == 2'd0) begin
                  accum_x_ff <= '0;
                  accum_y_ff <= '0;
               end
            end
            CMD_TICK: begin
               if (since_ff != TIME_MAX) begin
                  since_ff <= since_ff + 1'b1;
               end
            end
            CMD_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_item_ff.data_lines       <= lines_ff;
         rsp_item_ff.left_pulled_low  <= drive_ff[0];
         rsp_item_ff.right_pulled_low <= drive_ff[1];
         rsp_item_ff.nibble_phase     <= phase_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/mouse_delta_to_nibble_port.sv =====
// top level of the mouse report to strobed nibble port adapter
// depends on mdnp_pkg, mdnp_if, mdnp_ctrl and mdnp_dp
//
// Takes mouse reports, strobe edges and microsecond ticks on req_chan, one
// response per item on rsp_chan. One item is in work at a time. A report is
// loaded into the output register after its transfer through the steps
// divisor step, quotient, accumulate and output load; a strobe edge, tick or
// unused command goes through the apply and output load steps only. The
// response sits in an output register, so the next item is accepted as soon
// as the previous one is loaded even if rsp_chan is stalled; a second result
// waits in the final step until the register frees. Divide by six uses a
// reciprocal multiply. csr_chan writes the strobe timeout in microseconds and
// is always ready; write it only while the block is idle.
module mouse_delta_to_nibble_port import mdnp_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mdnp_req_if.sink   req_chan,
   mdnp_rsp_if.source rsp_chan,
   mdnp_csr_if.sink   csr_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   req_item_type  req_item;
   rsp_item_type  rsp_item;
   logic          req_ready;
   logic          rsp_valid;

   // request payload
   always_comb begin
      req_item.command     = cmd_type'(req_chan.command);
      req_item.buttons     = req_chan.buttons;
      req_item.delta_x     = req_chan.delta_x;
      req_item.delta_y     = req_chan.delta_y;
      req_item.edge_rising = req_chan.edge_rising;
   end

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   mdnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mdnp_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .csr_write (csr_chan.valid),
      .csr_data  (csr_chan.data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   // response ports
   assign rsp_chan.valid            = rsp_valid;
   assign rsp_chan.data_lines       = rsp_item.data_lines;
   assign rsp_chan.left_pulled_low  = rsp_item.left_pulled_low;
   assign rsp_chan.right_pulled_low = rsp_item.right_pulled_low;
   assign rsp_chan.nibble_phase     = rsp_item.nibble_phase;

   // one item in work: no transfer right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous item still in work");

   // datapath steps never overlap
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.step_div, cmd.step_quot, cmd.step_apply, cmd.load_out}))
      else $error("overlapping datapath steps");

   // a pending response is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !status.out_busy)
      else $error("output register loaded while response pending");

   // a loaded response is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded response not offered");

endmodule
